FILE: sv/dlspr_pkg.sv
// Shared types, command codes and helpers for the dual-link shortest-path router.
`default_nettype none
package dlspr_pkg;

	// Input beat: a load writes one edge, a run starts a search
	typedef struct packed {
		logic       op;
		logic [4:0] row;
		logic [4:0] col;
		logic [1:0] mesh_code;
		logic [1:0] fiveg_code;
		logic [4:0] source;
	} dlspr_in_t;

	// Result beat: one per reported node
	typedef struct packed {
		logic [4:0] node;
		logic       has_route;
		logic [6:0] distance;
		logic [4:0] hops;
		logic [4:0] next_hop;
		logic       link_type;
		logic       last;
	} dlspr_out_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	// Commands from controller to datapath
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_CLR,
		CMD_LOAD,
		CMD_RUN,
		CMD_INIT,
		CMD_PICK,
		CMD_MARK,
		CMD_RELAX
	} dlspr_kind_t;

	typedef struct packed {
		dlspr_kind_t kind;
		logic        emit;
		logic        last;
	} dlspr_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic u_inf;
	} dlspr_status_t;

	// Signal code 3/2/1 -> weight 1/2/3, code 0 -> no link
	function automatic logic [1:0] code_weight(input logic [1:0] code);
		logic [1:0] w;
		w = (code == 2'd0) ? 2'd0 : 2'(3'd4 - {1'b0, code});
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: sv/dlspr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dlspr_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: sv/dlspr_dpath.sv
// Datapath: weight and node-state memories, minimum search, relaxation, result register.
`default_nettype none
module dlspr_dpath #(
	parameter int NODES = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire dlspr_pkg::dlspr_in_t         req,
	input  wire dlspr_pkg::dlspr_cmd_t        cmd,
	input  wire logic [$clog2(NODES)-1:0]     idx,
	output dlspr_pkg::dlspr_status_t          status,
	output logic                              result_valid,
	output dlspr_pkg::dlspr_out_t             result
);
	import dlspr_pkg::*;

	localparam int IDXW = $clog2(NODES);
	localparam int DW   = $clog2(3 * NODES);
	localparam int WAW  = 2 * IDXW;
	localparam logic [DW-1:0] DINF = {DW{1'b1}};

	typedef struct packed {
		logic [DW-1:0]   cost;
		logic            vis;
		logic [4:0]      hops;
		logic [IDXW-1:0] relay;
		logic            lt;
		logic            rv;
	} node_t;

	// weight memory: {mesh, 5G} weights per edge
	logic           w_we;
	logic [WAW-1:0] w_waddr;
	logic [3:0]     w_wdata;
	logic [3:0]     w_rdata;
	logic [WAW-1:0] clr_q;
	logic           load_ok;

	// node memory
	logic            n_we;
	logic [IDXW-1:0] n_waddr;
	node_t           n_wdata;
	node_t           n_rdata;

	// pipeline and search registers
	dlspr_kind_t     kind_s1;
	logic            emit_s1;
	logic            last_s1;
	logic [IDXW-1:0] idx_s1;
	logic [IDXW-1:0] src_q;
	logic [IDXW-1:0] u_q;
	logic [DW-1:0]   best_q;
	node_t           u_ent_q;

	// relaxation terms
	logic [1:0]      wm, wf, w;
	logic            lt_new;
	logic [DW:0]     nd;
	logic            improve;
	logic [DW-1:0]   cmp_best;
	node_t           relax_ent;
	logic [6:0]      dout;

	assign load_ok = (32'(req.row) < NODES) && (32'(req.col) < NODES);

	// weight write: clearing sweep after reset or one edge load
	always_comb begin
		w_we    = 1'b0;
		w_waddr = clr_q;
		w_wdata = 4'd0;
		if (cmd.kind == CMD_CLR) begin
			w_we = 1'b1;
		end else if (cmd.kind == CMD_LOAD && load_ok) begin
			w_we    = 1'b1;
			w_waddr = {IDXW'(req.row), IDXW'(req.col)};
			if (req.row != req.col) begin
				w_wdata = {code_weight(req.mesh_code), code_weight(req.fiveg_code)};
			end
		end
	end

	dlspr_ram #(.WIDTH(4), .DEPTH(1 << WAW)) u_wram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.raddr ({u_q, idx}),
		.rdata (w_rdata)
	);

	// cheaper nonzero link, 5G wins ties
	always_comb begin
		wm = w_rdata[3:2];
		wf = w_rdata[1:0];
		if (wf == 2'd0) begin
			w = wm; lt_new = 1'b0;
		end else if (wm == 2'd0 || wf <= wm) begin
			w = wf; lt_new = 1'b1;
		end else begin
			w = wm; lt_new = 1'b0;
		end
		nd = {1'b0, u_ent_q.cost} + (DW+1)'(w);
		improve = !n_rdata.vis && (w_rdata != 4'd0) && (nd < {1'b0, n_rdata.cost});
		relax_ent       = n_rdata;
		relax_ent.cost  = nd[DW-1:0];
		relax_ent.rv    = 1'b1;
		relax_ent.hops  = (u_ent_q.hops == 5'd31) ? 5'd31 : u_ent_q.hops + 5'd1;
		if (u_ent_q.hops == 5'd0) begin
			relax_ent.relay = src_q;
			relax_ent.lt    = lt_new;
		end else if (u_ent_q.hops == 5'd1) begin
			relax_ent.relay = u_q;
			relax_ent.lt    = u_ent_q.lt;
		end else begin
			relax_ent.relay = u_ent_q.relay;
			relax_ent.lt    = u_ent_q.lt;
		end
	end

	// node write: init sweep, visit mark, or relaxation update
	always_comb begin
		n_we    = 1'b0;
		n_waddr = idx;
		n_wdata = '0;
		if (cmd.kind == CMD_INIT) begin
			n_we = 1'b1;
			n_wdata.cost  = (idx == src_q) ? '0 : DINF;
			n_wdata.relay = (idx == src_q) ? src_q : '0;
		end else if (cmd.kind == CMD_MARK) begin
			n_we        = 1'b1;
			n_waddr     = u_q;
			n_wdata     = u_ent_q;
			n_wdata.vis = 1'b1;
		end else if (kind_s1 == CMD_RELAX && improve) begin
			n_we    = 1'b1;
			n_waddr = idx_s1;
			n_wdata = relax_ent;
		end
	end

	dlspr_ram #(.WIDTH($bits(node_t)), .DEPTH(1 << IDXW)) u_nram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.raddr (idx),
		.rdata (n_rdata)
	);

	assign cmp_best = (idx_s1 == '0) ? DINF : best_q;

	// reported distance: unreachable 127, saturate at 126
	always_comb begin
		if (n_rdata.cost == DINF) begin
			dout = 7'd127;
		end else if (32'(n_rdata.cost) > 126) begin
			dout = 7'd126;
		end else begin
			dout = 7'(n_rdata.cost);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1      <= CMD_NONE;
			emit_s1      <= 1'b0;
			clr_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			kind_s1      <= cmd.kind;
			emit_s1      <= cmd.emit;
			result_valid <= emit_s1;
			if (cmd.kind == CMD_CLR) begin
				clr_q <= clr_q + WAW'(1);
			end
		end
	end

	// payload registers: search state and result beat
	always_ff @(posedge clk) begin
		idx_s1  <= idx;
		last_s1 <= cmd.last;
		if (cmd.kind == CMD_RUN) begin
			src_q <= IDXW'(req.source);
		end
		// last unvisited node of least distance
		if (kind_s1 == CMD_PICK) begin
			if (!n_rdata.vis && n_rdata.cost <= cmp_best) begin
				best_q  <= n_rdata.cost;
				u_q     <= idx_s1;
				u_ent_q <= n_rdata;
			end else if (idx_s1 == '0) begin
				best_q <= DINF;
				u_q    <= '0;
			end
		end
		if (emit_s1) begin
			result.node      <= 5'(idx_s1);
			result.has_route <= n_rdata.rv;
			result.distance  <= dout;
			result.hops      <= n_rdata.hops;
			result.next_hop  <= 5'(n_rdata.relay);
			result.link_type <= n_rdata.lt;
			result.last      <= last_s1;
		end
	end

	assign status.clr_last = (clr_q == {WAW{1'b1}});
	assign status.u_inf    = (best_q == DINF);
endmodule
`default_nettype wire

FILE: sv/dlspr_ctrl.sv
// Controller: sequences clearing, loads, init sweep, search rounds and result sweep.
`default_nettype none
module dlspr_ctrl #(
	parameter int NODES = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire dlspr_pkg::dlspr_in_t      req,
	input  wire dlspr_pkg::dlspr_status_t  status,
	output logic                           busy,
	output dlspr_pkg::dlspr_cmd_t          cmd,
	output logic [$clog2(NODES)-1:0]       idx
);
	import dlspr_pkg::*;

	localparam int IDXW = $clog2(NODES);
	localparam int OUTN = (NODES > 32) ? 32 : NODES;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_INIT, S_PICK, S_DRAIN, S_MARK, S_RELAX, S_EMIT
	} state_t;

	state_t          state_q;
	logic [IDXW-1:0] cnt_q;
	logic [IDXW-1:0] round_q;
	logic            cnt_end;
	logic            round_end;

	assign cnt_end   = (cnt_q == IDXW'(NODES - 1));
	assign round_end = (round_q == IDXW'(NODES - 2));
	assign busy      = (state_q != S_IDLE);
	assign idx       = cnt_q;

	// commands decoded from state
	always_comb begin
		cmd.kind = CMD_NONE;
		cmd.emit = 1'b0;
		cmd.last = 1'b0;
		case (state_q)
			S_CLEAR: cmd.kind = CMD_CLR;
			S_IDLE: begin
				if (start && req.op == OP_LOAD) begin
					cmd.kind = CMD_LOAD;
				end else if (start && 32'(req.source) < NODES) begin
					cmd.kind = CMD_RUN;
				end
			end
			S_INIT:  cmd.kind = CMD_INIT;
			S_PICK:  cmd.kind = CMD_PICK;
			S_MARK:  cmd.kind = CMD_MARK;
			S_RELAX: cmd.kind = CMD_RELAX;
			S_EMIT: begin
				cmd.emit = 1'b1;
				cmd.last = (cnt_q == IDXW'(OUTN - 1));
			end
			default: cmd.kind = CMD_NONE;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
			round_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (status.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					cnt_q   <= '0;
					round_q <= '0;
					if (cmd.kind == CMD_RUN) state_q <= S_INIT;
				end
				S_INIT: begin
					cnt_q <= cnt_end ? '0 : cnt_q + IDXW'(1);
					if (cnt_end) state_q <= S_PICK;
				end
				S_PICK: begin
					cnt_q <= cnt_end ? '0 : cnt_q + IDXW'(1);
					if (cnt_end) state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_MARK;
				S_MARK: begin
					if (!status.u_inf) begin
						state_q <= S_RELAX;
					end else if (round_end) begin
						state_q <= S_EMIT;
					end else begin
						round_q <= round_q + IDXW'(1);
						state_q <= S_PICK;
					end
				end
				S_RELAX: begin
					cnt_q <= cnt_end ? '0 : cnt_q + IDXW'(1);
					if (cnt_end) begin
						if (round_end) begin
							state_q <= S_EMIT;
						end else begin
							round_q <= round_q + IDXW'(1);
							state_q <= S_PICK;
						end
					end
				end
				S_EMIT: begin
					cnt_q <= cnt_q + IDXW'(1);
					if (cmd.last) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: sv/dual_link_shortest_path_router_unit.sv
// Top level of the dual-link shortest-path router.
// A load beat (op 0) writes one edge of the mesh and 5G weight matrices. A run beat (op 1)
// performs NODES-1 search rounds; each round scans all nodes for the minimum and, for a
// reachable pick, relaxes every node against the picked row, all through one-read, one-write
// node and weight memories, one node per cycle. A run with a valid source stays busy through
// the init sweep, the search rounds and the result sweep, and streams min(NODES,32) result
// beats, one per cycle, marked by result_valid; the receiver cannot stall them. Each beat
// passes the node memory's read register and then the result register, so the final two
// beats trail the fall of busy. A run with an out-of-range source returns no beats. After
// reset all 2^(2*clog2(NODES)) weight memory entries are cleared, one entry per cycle, with
// busy high.
`default_nettype none
module dual_link_shortest_path_router_unit #(
	parameter int NODES = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire dlspr_pkg::dlspr_in_t  req,
	output logic                       busy,
	output logic                       result_valid,
	output dlspr_pkg::dlspr_out_t      result
);
	import dlspr_pkg::*;

	dlspr_cmd_t                cmd;
	dlspr_status_t             status;
	logic [$clog2(NODES)-1:0]  idx;

	dlspr_ctrl #(.NODES(NODES)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.status (status),
		.busy   (busy),
		.cmd    (cmd),
		.idx    (idx)
	);

	dlspr_dpath #(.NODES(NODES)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.cmd          (cmd),
		.idx          (idx),
		.status       (status),
		.result_valid (result_valid),
		.result       (result)
	);
endmodule
`default_nettype wire

FILE: bench/dlspr_route_checker.sv
// Route checker: tracks the edge matrices, predicts route beats and compares them.
`default_nettype none
module dlspr_route_checker (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire dlspr_pkg::dlspr_in_t  req,
	input  wire logic                  result_valid,
	input  wire dlspr_pkg::dlspr_out_t result,
	output int                         fail_count,
	output int                         routes_pending,
	output int                         routes_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import dlspr_pkg::*;

	localparam int N        = 32;
	localparam int DIST_INF = 'hFFFF;

	logic [1:0] mesh_w  [N][N];
	logic [1:0] fiveg_w [N][N];
	dlspr_out_t route_q [$];

	// Signal code to weight: 3/2/1 -> 1/2/3, 0 -> no link
	function automatic logic [1:0] link_cost(input logic [1:0] code);
		return (code == 2'd0) ? 2'd0 : 2'(3 - int'(code) + 1);
	endfunction

	// Dijkstra over the combined graph, one beat queued per node
	task automatic queue_routes(input logic [4:0] src);
		int cost [N];
		bit seen [N];
		bit valid [N];
		int hop [N];
		int relay [N];
		bit ltype [N];
		int best, u, nd, h;
		logic [1:0] m, f, w;
		bit lt;
		dlspr_out_t r;
		for (int v = 0; v < N; v++) begin
			cost[v] = DIST_INF; seen[v] = 0; valid[v] = 0;
			hop[v] = 0; relay[v] = 0; ltype[v] = 0;
		end
		cost[src] = 0;
		relay[src] = src;
		for (int rnd = 0; rnd < N - 1; rnd++) begin
			// last unvisited node of least distance
			best = DIST_INF;
			u = 0;
			for (int v = 0; v < N; v++)
				if (!seen[v] && cost[v] <= best) begin
					best = cost[v];
					u = v;
				end
			seen[u] = 1;
			if (cost[u] == DIST_INF)
				continue;
			for (int v = 0; v < N; v++) begin
				if (seen[v])
					continue;
				m = mesh_w[u][v];
				f = fiveg_w[u][v];
				if (m == 0 && f == 0)
					continue;
				// cheaper link wins, 5G on a tie
				if (f == 0) begin
					w = m; lt = 0;
				end else if (m == 0 || f <= m) begin
					w = f; lt = 1;
				end else begin
					w = m; lt = 0;
				end
				nd = cost[u] + w;
				if (nd < cost[v]) begin
					h = hop[u] + 1;
					cost[v] = nd;
					valid[v] = 1;
					hop[v] = (h > 31) ? 31 : h;
					if (hop[u] == 0) begin
						relay[v] = src; ltype[v] = lt;
					end else if (hop[u] == 1) begin
						relay[v] = u; ltype[v] = ltype[u];
					end else begin
						relay[v] = relay[u]; ltype[v] = ltype[u];
					end
				end
			end
		end
		for (int v = 0; v < N; v++) begin
			r.node      = 5'(v);
			r.has_route = valid[v];
			r.distance  = (cost[v] == DIST_INF) ? 7'd127 :
				(cost[v] > 126 ? 7'd126 : 7'(cost[v]));
			r.hops      = 5'(hop[v]);
			r.next_hop  = 5'(relay[v]);
			r.link_type = ltype[v];
			r.last      = (v == N - 1);
			route_q.insert(route_q.size(), r);
		end
	endtask

	task automatic check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			$display("%0t ns: route mismatch on %s: expected %0d, actual %0d",
				$realtime, name, exp_v, got_v);
			fail_count++;
		end
	endtask

	// Watch both channels; a result beat is checked before a new beat is taken
	always @(posedge clk or negedge arst_n) begin
		dlspr_out_t e;
		if (!arst_n) begin
			fail_count <= 0;
			routes_seen <= 0;
			routes_pending <= 0;
			route_q.delete();
			for (int i = 0; i < N; i++)
				for (int j = 0; j < N; j++) begin
					mesh_w[i][j] = 2'd0;
					fiveg_w[i][j] = 2'd0;
				end
		end else begin
			if (result_valid) begin
				routes_seen <= routes_seen + 1;
				if (route_q.size() == 0) begin
					$display("%0t ns: unexpected route beat: expected none, actual %p",
						$realtime, result);
					fail_count++;
				end else begin
					e = route_q.pop_front();
					check_field("node", e.node, result.node);
					check_field("has_route", e.has_route, result.has_route);
					check_field("distance", e.distance, result.distance);
					check_field("hops", e.hops, result.hops);
					check_field("next_hop", e.next_hop, result.next_hop);
					check_field("link_type", e.link_type, result.link_type);
					check_field("last", e.last, result.last);
				end
			end
			if (start && !busy) begin
				if (req.op == OP_LOAD) begin
					// diagonal is always stored as no link
					mesh_w[req.row][req.col] =
						(req.row == req.col) ? 2'd0 : link_cost(req.mesh_code);
					fiveg_w[req.row][req.col] =
						(req.row == req.col) ? 2'd0 : link_cost(req.fiveg_code);
				end else
					queue_routes(req.source);
			end
			routes_pending <= route_q.size();
		end
	end
endmodule
`default_nettype wire

FILE: bench/tb_dual_link_shortest_path_router_unit.sv
// Testbench top: drives load and run beats into the router and reports the verdict.
`default_nettype none
module tb_dual_link_shortest_path_router_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import dlspr_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int IN_W        = $bits(dlspr_in_t);

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	dlspr_in_t  req = '0;
	logic       busy;
	logic       result_valid;
	dlspr_out_t result;
	int         fail_count, routes_pending, routes_seen;
	int         cycles = 0;
	int         loads = 0, runs = 0;
	bit         no_gaps = 0;

	always #6 clk = ~clk;

	dual_link_shortest_path_router_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .result_valid(result_valid), .result(result)
	);

	dlspr_route_checker i_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.result_valid(result_valid), .result(result),
		.fail_count(fail_count), .routes_pending(routes_pending),
		.routes_seen(routes_seen)
	);

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_dual_link_shortest_path_router_unit NOT OK");
			$finish;
		end
	end

	// Present one beat after a random gap; returns at the accepting edge with start still high
	task automatic send_beat(input dlspr_in_t b);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= b;
		do @(negedge clk); while (busy);
		@(posedge clk);
		if (b.op == OP_LOAD) loads++; else runs++;
	endtask

	task automatic load_edge(input int r, input int c, input int mc, input int fc);
		dlspr_in_t b;
		b = dlspr_in_t'(IN_W'($urandom));
		b.op = OP_LOAD; b.row = 5'(r); b.col = 5'(c);
		b.mesh_code = 2'(mc); b.fiveg_code = 2'(fc);
		send_beat(b);
	endtask

	task automatic run_from(input int s);
		dlspr_in_t b;
		b = dlspr_in_t'(IN_W'($urandom));
		b.op = OP_RUN; b.source = 5'(s);
		send_beat(b);
	endtask

	initial begin
		int n, base, len;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty graph, extremes, ties, diagonal, chains
		run_from(0);
		load_edge(0, 31, 3, 0);
		load_edge(0, 1, 1, 3);
		load_edge(1, 2, 2, 2);
		load_edge(2, 3, 3, 1);
		load_edge(3, 4, 0, 2);
		load_edge(4, 5, 2, 3);
		load_edge(5, 5, 3, 3);
		load_edge(31, 0, 3, 3);
		load_edge(31, 30, 1, 1);
		load_edge(30, 29, 2, 0);
		load_edge(0, 2, 1, 1);
		run_from(0);
		run_from(31);
		load_edge(0, 31, 0, 0);
		load_edge(31, 31, 3, 3);
		load_edge(29, 28, 3, 3);
		run_from(31);
		run_from(5);

		// Pause until every route beat is back
		start <= 1'b0;
		do @(negedge clk); while (routes_pending != 0);
		@(posedge clk);

		// Random: chains with random codes, stray edges, runs at random intervals
		n = 0;
		while (n < 100) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 2))
				0: begin
					base = $urandom_range(0, 31);
					len = $urandom_range(2, 8);
					for (int k = 0; k < len; k++) begin
						load_edge((base + k) % 32, (base + k + 1) % 32,
							$urandom_range(0, 3), $urandom_range(0, 3));
						n++;
					end
				end
				default: begin
					load_edge($urandom_range(0, 31), $urandom_range(0, 31),
						$urandom_range(0, 3), $urandom_range(0, 3));
					n++;
				end
			endcase
			if ($urandom_range(0, 5) == 0) begin
				run_from($urandom_range(0, 31));
				n++;
			end
		end
		run_from($urandom_range(0, 31));
		start <= 1'b0;

		// Drain
		do @(negedge clk); while (routes_pending != 0);
		repeat (40) @(posedge clk);
		$display("covered %0d edge loads and %0d searches, %0d route beats checked",
			loads, runs, routes_seen);
		if (fail_count == 0)
			$display("tb_dual_link_shortest_path_router_unit OK");
		else
			$display("tb_dual_link_shortest_path_router_unit NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
sv/dlspr_pkg.sv
sv/dlspr_ram.sv
sv/dlspr_dpath.sv
sv/dlspr_ctrl.sv
sv/dual_link_shortest_path_router_unit.sv
bench/dlspr_route_checker.sv
bench/tb_dual_link_shortest_path_router_unit.sv
